// ----- hw/rtl/periodic_lattice_pair_search_core_assert.svh -----
// Assertion macros shared by the pair search core.
`ifndef PERIODIC_LATTICE_PAIR_SEARCH_CORE_ASSERT_SVH
`define PERIODIC_LATTICE_PAIR_SEARCH_CORE_ASSERT_SVH
`ifndef SYNTH
`define PLS_ASSERT(name, clk, rst, prop) \
  name: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("pair search assertion failed");
`define PLS_ASSERT_ALWAYS(name, clk, prop) \
  name: assert property (@(posedge clk) prop) \
    else $error("pair search assertion failed");
`else
`define PLS_ASSERT(name, clk, rst, prop)
`define PLS_ASSERT_ALWAYS(name, clk, prop)
`endif
`endif

// ----- hw/rtl/pls_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pls_pkg
// Types and constants of the periodic lattice pair search core.
// ----------------------------------------------------------------------------
package pls_pkg;

  localparam int IDW  = 18;  // site id width
  localparam int SW   = 7;   // lattice edge width
  localparam int S2W  = 14;  // squared edge width
  localparam int QW   = 14;  // squared distance width
  localparam int CFGW = 12;  // configuration data width
  localparam int BW   = 12;  // bound width
  localparam int CMDW = 2;
  localparam int CIW  = 2;   // configuration index width

  localparam logic [CMDW-1:0] CMD_CLEAR = 2'd0;
  localparam logic [CMDW-1:0] CMD_LOAD  = 2'd1;
  localparam logic [CMDW-1:0] CMD_FETCH = 2'd2;

  localparam logic [CIW-1:0] CFG_LATTICE = 2'd0;
  localparam logic [CIW-1:0] CFG_INNER   = 2'd1;
  localparam logic [CIW-1:0] CFG_OUTER   = 2'd2;

  localparam logic [SW-1:0] LATTICE_RESET = 7'd16;
  localparam logic [BW-1:0] INNER_RESET   = 12'd0;
  localparam logic [BW-1:0] OUTER_RESET   = 12'd3073;

  typedef enum logic [2:0] {
    DIV_AZ, DIV_AY, DIV_BZ, DIV_BY, DIV_ZM
  } div_sel_t;

  typedef enum logic [1:0] {
    RD_POS, RD_I, RD_J
  } rd_sel_t;

  typedef struct packed {
    logic     take_id;
    logic     clear;
    logic     ld_init;
    logic     set_ovf;
    logic     wr_shift;
    logic     wr_id;
    logic     pos_dec;
    logic     rd_en;
    rd_sel_t  rd_sel;
    logic     latch_a;
    logic     latch_b;
    logic     j_inc;
    logic     next_i;
    logic     div_start;
    div_sel_t div_sel;
    logic     calc_c;
    logic     calc_q;
    logic     out_load;
    logic     out_found;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic pos_zero;
    logic shift_gt;
    logic i_lt_cnt;
    logic j_lt_cnt;
    logic a_lt_b;
    logic div_busy;
    logic div_done;
    logic pass;
  } sts_t;

endpackage

// ----- hw/rtl/pls_div.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pls_div
// Restoring divider, one quotient bit per cycle, quotient and remainder.
// ----------------------------------------------------------------------------
module pls_div (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  input  logic [pls_pkg::IDW-1:0]  num,
  input  logic [pls_pkg::S2W-1:0]  den,
  output logic                     busy,
  output logic                     done,
  output logic [pls_pkg::IDW-1:0]  quot,
  output logic [pls_pkg::S2W-1:0]  rem
);

  localparam int CNTW = $clog2(pls_pkg::IDW + 1);

  logic [CNTW-1:0]          cnt;
  logic [pls_pkg::S2W-1:0]  den_r;
  logic [pls_pkg::S2W:0]    shifted;
  logic [pls_pkg::S2W:0]    trial;

  assign shifted = {rem, quot[pls_pkg::IDW-1]};
  assign trial   = shifted - {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start && !busy) begin
        busy <= 1'b1;
        cnt  <= CNTW'(pls_pkg::IDW);
      end else if (busy) begin
        cnt <= cnt - CNTW'(1);
        if (cnt == CNTW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      rem   <= '0;
      quot  <= num;
      den_r <= den;
    end else if (busy) begin
      if (!trial[pls_pkg::S2W]) begin
        rem  <= trial[pls_pkg::S2W-1:0];
        quot <= {quot[pls_pkg::IDW-2:0], 1'b1};
      end else begin
        rem  <= shifted[pls_pkg::S2W-1:0];
        quot <= {quot[pls_pkg::IDW-2:0], 1'b0};
      end
    end
  end

endmodule

// ----- hw/rtl/pls_datapath.sv -----
`timescale 1ns / 1ps
`include "periodic_lattice_pair_search_core_assert.svh"
// ----------------------------------------------------------------------------
// pls_datapath
// Sorted site store, cursors, coordinate split and distance test.
// ----------------------------------------------------------------------------
module pls_datapath #(
  parameter int MAX_SITES   = 1024,
  parameter int MAX_LATTICE = 64
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_we,
  input  logic [pls_pkg::CIW-1:0]   cfg_index,
  input  logic [pls_pkg::CFGW-1:0]  cfg_data,
  input  logic [pls_pkg::IDW-1:0]   site_id,
  input  pls_pkg::cmd_t             cmd,
  output pls_pkg::sts_t             sts,
  output logic [pls_pkg::IDW-1:0]   pair_first,
  output logic [pls_pkg::IDW-1:0]   pair_second,
  output logic                      pair_found,
  output logic                      done_res,
  output logic                      overflow
);

  localparam int AW   = (MAX_SITES > 1) ? $clog2(MAX_SITES) : 1;
  localparam int CW   = $clog2(MAX_SITES + 1);
  localparam int SMAX = (MAX_LATTICE > 127) ? 127 : MAX_LATTICE;
  localparam int SW   = pls_pkg::SW;
  localparam int IDW  = pls_pkg::IDW;
  localparam int S2W  = pls_pkg::S2W;
  localparam int QW   = pls_pkg::QW;

  logic [SW-1:0]          lattice_size;
  logic [pls_pkg::BW-1:0] inner_bound_sq;
  logic [pls_pkg::BW-1:0] outer_bound_sq;

  logic [SW-1:0]  s_eff;
  logic [S2W-1:0] s2;

  logic [IDW-1:0] mem [MAX_SITES];
  logic [IDW-1:0] mem_q;
  logic [CW-1:0]  rd_addr;
  logic           wr_en;
  logic [IDW-1:0] wr_data;

  logic [CW-1:0]  count, pos, i, j;
  logic           ovf;
  logic [IDW-1:0] id_reg, a_reg, b_reg;

  logic [IDW-1:0] za, zb;
  logic [S2W-1:0] ra, rb;
  logic [SW-1:0]  xa, ya, xb, yb, rz;
  logic [SW-1:0]  cx, cy, cz;
  logic [QW-1:0]  q;

  logic           div_busy, div_done;
  logic [IDW-1:0] div_num, div_quot;
  logic [S2W-1:0] div_den, div_rem;

  // Fold an axis offset below s onto its minimum image.
  function automatic logic [SW-1:0] fold(input logic [SW-1:0] r, input logic [SW-1:0] s);
    logic [SW-1:0] m;
    m = s - r;
    return (m < r) ? m : r;
  endfunction

  function automatic logic [SW-1:0] absdiff(input logic [SW-1:0] u, input logic [SW-1:0] v);
    return (u > v) ? (u - v) : (v - u);
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      lattice_size   <= pls_pkg::LATTICE_RESET;
      inner_bound_sq <= pls_pkg::INNER_RESET;
      outer_bound_sq <= pls_pkg::OUTER_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        pls_pkg::CFG_LATTICE: lattice_size   <= cfg_data[SW-1:0];
        pls_pkg::CFG_INNER:   inner_bound_sq <= cfg_data[pls_pkg::BW-1:0];
        pls_pkg::CFG_OUTER:   outer_bound_sq <= cfg_data[pls_pkg::BW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (lattice_size == '0) begin
      s_eff = SW'(1);
    end else if (lattice_size > SW'(SMAX)) begin
      s_eff = SW'(SMAX);
    end else begin
      s_eff = lattice_size;
    end
    s2 = S2W'(s_eff) * S2W'(s_eff);
  end

  // Store: one write port, one registered read port.
  always_comb begin
    case (cmd.rd_sel)
      pls_pkg::RD_POS: rd_addr = pos - CW'(1);
      pls_pkg::RD_I:   rd_addr = i;
      pls_pkg::RD_J:   rd_addr = j;
      default:         rd_addr = i;
    endcase
  end

  assign wr_en   = cmd.wr_shift || cmd.wr_id;
  assign wr_data = cmd.wr_shift ? mem_q : id_reg;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[pos[AW-1:0]] <= wr_data;
    end
    if (cmd.rd_en) begin
      mem_q <= mem[rd_addr[AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      pos   <= '0;
      i     <= '0;
      j     <= '0;
      ovf   <= 1'b0;
    end else begin
      if (cmd.clear) begin
        count <= '0;
        i     <= '0;
        j     <= '0;
        ovf   <= 1'b0;
      end
      if (cmd.set_ovf) begin
        ovf <= 1'b1;
      end
      if (cmd.ld_init) begin
        pos <= count;
      end
      if (cmd.pos_dec) begin
        pos <= pos - CW'(1);
      end
      if (cmd.wr_id) begin
        count <= count + CW'(1);
        i     <= '0;
        j     <= '0;
      end
      if (cmd.next_i) begin
        i <= i + CW'(1);
        j <= i + CW'(2);
      end
      if (cmd.j_inc) begin
        j <= j + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take_id) id_reg <= site_id;
    if (cmd.latch_a) a_reg <= mem_q;
    if (cmd.latch_b) b_reg <= mem_q;
  end

  always_comb begin
    case (cmd.div_sel)
      pls_pkg::DIV_AZ: begin
        div_num = a_reg;
        div_den = s2;
      end
      pls_pkg::DIV_AY: begin
        div_num = IDW'(ra);
        div_den = S2W'(s_eff);
      end
      pls_pkg::DIV_BZ: begin
        div_num = b_reg;
        div_den = s2;
      end
      pls_pkg::DIV_BY: begin
        div_num = IDW'(rb);
        div_den = S2W'(s_eff);
      end
      pls_pkg::DIV_ZM: begin
        div_num = (za > zb) ? (za - zb) : (zb - za);
        div_den = S2W'(s_eff);
      end
      default: begin
        div_num = a_reg;
        div_den = s2;
      end
    endcase
  end

  pls_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.div_start),
    .num   (div_num),
    .den   (div_den),
    .busy  (div_busy),
    .done  (div_done),
    .quot  (div_quot),
    .rem   (div_rem)
  );

  always_ff @(posedge clk) begin
    if (div_done) begin
      case (cmd.div_sel)
        pls_pkg::DIV_AZ: begin
          za <= div_quot;
          ra <= div_rem;
        end
        pls_pkg::DIV_AY: begin
          ya <= div_quot[SW-1:0];
          xa <= div_rem[SW-1:0];
        end
        pls_pkg::DIV_BZ: begin
          zb <= div_quot;
          rb <= div_rem;
        end
        pls_pkg::DIV_BY: begin
          yb <= div_quot[SW-1:0];
          xb <= div_rem[SW-1:0];
        end
        pls_pkg::DIV_ZM: rz <= div_rem[SW-1:0];
        default: ;
      endcase
    end
    if (cmd.calc_c) begin
      cx <= fold(absdiff(xa, xb), s_eff);
      cy <= fold(absdiff(ya, yb), s_eff);
      cz <= fold(rz, s_eff);
    end
    if (cmd.calc_q) begin
      q <= QW'(cx) * QW'(cx) + QW'(cy) * QW'(cy) + QW'(cz) * QW'(cz);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      pair_first  <= cmd.out_found ? a_reg : '0;
      pair_second <= cmd.out_found ? b_reg : '0;
      pair_found  <= cmd.out_found;
      done_res    <= !cmd.out_found;
      overflow    <= ovf;
    end
  end

  always_comb begin
    sts.full     = (count >= CW'(MAX_SITES));
    sts.pos_zero = (pos == '0);
    sts.shift_gt = (mem_q > id_reg);
    sts.i_lt_cnt = (i < count);
    sts.j_lt_cnt = (j < count);
    sts.a_lt_b   = (a_reg < mem_q);
    sts.div_busy = div_busy;
    sts.div_done = div_done;
    sts.pass     = (q > QW'(inner_bound_sq)) && (q < QW'(outer_bound_sq));
  end

  `PLS_ASSERT(a_count_bound, clk, rst, count <= CW'(MAX_SITES))
  `PLS_ASSERT(a_shift_moves_down, clk, rst, cmd.wr_shift |=> (pos == $past(pos) - CW'(1)))
  `PLS_ASSERT(a_div_idle_start, clk, rst, cmd.div_start |-> !div_busy)
  `PLS_ASSERT(a_found_ordered, clk, rst, (cmd.out_load && cmd.out_found) |-> (a_reg < b_reg))

endmodule

// ----- hw/rtl/pls_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pls_ctrl
// Sequencer for clear, sorted insertion and the pair scan.
// ----------------------------------------------------------------------------
module pls_ctrl (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [pls_pkg::CMDW-1:0]  command,
  output logic                      out_valid,
  input  logic                      out_ready,
  input  pls_pkg::sts_t             sts,
  output pls_pkg::cmd_t             cmd
);

  typedef enum logic [16:0] {
    S_IDLE    = 17'b00000000000000001,
    S_LD_CHK  = 17'b00000000000000010,
    S_LD_RD   = 17'b00000000000000100,
    S_LD_CMP  = 17'b00000000000001000,
    S_F_CHK   = 17'b00000000000010000,
    S_F_LA    = 17'b00000000000100000,
    S_F_AZ    = 17'b00000000001000000,
    S_F_AY    = 17'b00000000010000000,
    S_F_INNER = 17'b00000000100000000,
    S_F_BCMP  = 17'b00000001000000000,
    S_F_BZ    = 17'b00000010000000000,
    S_F_BY    = 17'b00000100000000000,
    S_F_ZM    = 17'b00001000000000000,
    S_F_DIST  = 17'b00010000000000000,
    S_F_SQ    = 17'b00100000000000000,
    S_F_TEST  = 17'b01000000000000000,
    S_RESP    = 17'b10000000000000000
  } state_t;

  state_t state, state_next;
  logic   found, found_next;
  logic   out_valid_next;
  logic   div_go;

  assign in_ready = (state == S_IDLE);
  assign div_go   = !sts.div_busy && !sts.div_done;

  always_comb begin
    state_next = state;
    found_next = found;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.take_id = 1'b1;
          case (command)
            pls_pkg::CMD_CLEAR: cmd.clear = 1'b1;
            pls_pkg::CMD_LOAD: begin
              cmd.ld_init = 1'b1;
              state_next  = S_LD_CHK;
            end
            pls_pkg::CMD_FETCH: state_next = S_F_CHK;
            default: ;
          endcase
        end
      end
      S_LD_CHK: begin
        if (sts.full) begin
          cmd.set_ovf = 1'b1;
          state_next  = S_IDLE;
        end else begin
          state_next = S_LD_RD;
        end
      end
      S_LD_RD: begin
        if (sts.pos_zero) begin
          cmd.wr_id  = 1'b1;
          state_next = S_IDLE;
        end else begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = pls_pkg::RD_POS;
          state_next = S_LD_CMP;
        end
      end
      S_LD_CMP: begin
        // Larger neighbors move up one slot until the new id fits.
        if (sts.shift_gt) begin
          cmd.wr_shift = 1'b1;
          cmd.pos_dec  = 1'b1;
          state_next   = S_LD_RD;
        end else begin
          cmd.wr_id  = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_F_CHK: begin
        if (sts.i_lt_cnt) begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = pls_pkg::RD_I;
          state_next = S_F_LA;
        end else begin
          found_next = 1'b0;
          state_next = S_RESP;
        end
      end
      S_F_LA: begin
        cmd.latch_a = 1'b1;
        state_next  = S_F_AZ;
      end
      S_F_AZ: begin
        cmd.div_sel   = pls_pkg::DIV_AZ;
        cmd.div_start = div_go;
        if (sts.div_done) state_next = S_F_AY;
      end
      S_F_AY: begin
        cmd.div_sel   = pls_pkg::DIV_AY;
        cmd.div_start = div_go;
        if (sts.div_done) state_next = S_F_INNER;
      end
      S_F_INNER: begin
        if (sts.j_lt_cnt) begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = pls_pkg::RD_J;
          cmd.j_inc  = 1'b1;
          state_next = S_F_BCMP;
        end else begin
          cmd.next_i = 1'b1;
          state_next = S_F_CHK;
        end
      end
      S_F_BCMP: begin
        cmd.latch_b = 1'b1;
        state_next  = sts.a_lt_b ? S_F_BZ : S_F_INNER;
      end
      S_F_BZ: begin
        cmd.div_sel   = pls_pkg::DIV_BZ;
        cmd.div_start = div_go;
        if (sts.div_done) state_next = S_F_BY;
      end
      S_F_BY: begin
        cmd.div_sel   = pls_pkg::DIV_BY;
        cmd.div_start = div_go;
        if (sts.div_done) state_next = S_F_ZM;
      end
      S_F_ZM: begin
        cmd.div_sel   = pls_pkg::DIV_ZM;
        cmd.div_start = div_go;
        if (sts.div_done) state_next = S_F_DIST;
      end
      S_F_DIST: begin
        cmd.calc_c = 1'b1;
        state_next = S_F_SQ;
      end
      S_F_SQ: begin
        cmd.calc_q = 1'b1;
        state_next = S_F_TEST;
      end
      S_F_TEST: begin
        if (sts.pass) begin
          found_next = 1'b1;
          state_next = S_RESP;
        end else begin
          state_next = S_F_INNER;
        end
      end
      S_RESP: begin
        // Wait until the output register is free for this transfer.
        if (!out_valid || out_ready) begin
          cmd.out_load  = 1'b1;
          cmd.out_found = found;
          state_next    = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    if (cmd.out_load) begin
      out_valid_next = 1'b1;
    end else if (out_ready) begin
      out_valid_next = 1'b0;
    end else begin
      out_valid_next = out_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      found     <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      found     <= found_next;
      out_valid <= out_valid_next;
    end
  end

endmodule

// ----- hw/rtl/periodic_lattice_pair_search_core.sv -----
`timescale 1ns / 1ps
// Clear completes straight from idle. A load checks for room, then reads the stored id below
// the free slot and moves each larger one up one slot before it writes the new id; a full
// store only sets overflow. A fetch splits each outer id through the divider into z, y and x
// and skips each candidate not above it; the rest get the same split and the bound test.
// One item is in work at a time; a fetch waits while the previous result is untaken.
// Synchronous reset restores the configuration defaults and clears control, count, cursors
// and the overflow flag; store contents stay undefined and need no clearing pass.
// ----------------------------------------------------------------------------
// periodic_lattice_pair_search_core
// Sorted site store with a periodic minimum-image neighbor pair scan.
// ----------------------------------------------------------------------------
module periodic_lattice_pair_search_core #(
  parameter int MAX_SITES   = 1024,
  parameter int MAX_LATTICE = 64
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [pls_pkg::CMDW-1:0]  command,
  input  logic [pls_pkg::IDW-1:0]   site_id,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [pls_pkg::IDW-1:0]   pair_first,
  output logic [pls_pkg::IDW-1:0]   pair_second,
  output logic                      pair_found,
  output logic                      done_res,
  output logic                      overflow,
  input  logic                      cfg_we,
  input  logic [pls_pkg::CIW-1:0]   cfg_index,
  input  logic [pls_pkg::CFGW-1:0]  cfg_data
);

  pls_pkg::cmd_t cmd;
  pls_pkg::sts_t sts;

  pls_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .command   (command),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  pls_datapath #(
    .MAX_SITES   (MAX_SITES),
    .MAX_LATTICE (MAX_LATTICE)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .site_id     (site_id),
    .cmd         (cmd),
    .sts         (sts),
    .pair_first  (pair_first),
    .pair_second (pair_second),
    .pair_found  (pair_found),
    .done_res    (done_res),
    .overflow    (overflow)
  );

endmodule
